@@ rtl/assert_macros.svh @@
// Assertion macros shared by the lease table RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lease table check failed");

// next-cycle implication, disabled while reset is low
`define LTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lease table check failed");

`endif

@@ rtl/lte_pkg.sv @@
// Lease table package: sizes, action and register codes, item and slot types.
// No dependencies; used by the interfaces, lte_slot and the top level.
package lte_pkg;

    localparam int SLOT_COUNT  = 4;
    localparam int CLASS_COUNT = 4;
    localparam int REQ_W       = 2;
    localparam int COORD_W     = 16;
    localparam int RIN_W       = 9;
    localparam int PRIO_W      = 8;
    localparam int RAD_W       = 8;
    localparam int LIFE_W      = 16;
    localparam int EPOCH_W     = 32;
    localparam int EXP_W       = EPOCH_W + 1;
    localparam int CNT32_W     = 32;
    localparam int ACTIVE_W    = 3;
    localparam int ACTIVE_MAX  = 7;
    localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    typedef enum logic [1:0] {
        ACT_REFRESH    = 2'd0,
        ACT_SET_RADIUS = 2'd1,
        ACT_TICK       = 2'd2,
        ACT_READ       = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLAYER_PRIO   = 3'd0,
        CFG_CAMERA_PRIO   = 3'd1,
        CFG_TELEPORT_PRIO = 3'd2,
        CFG_PRELOAD_PRIO  = 3'd3,
        CFG_PLAYER_LIFE   = 3'd4,
        CFG_CAMERA_LIFE   = 3'd5,
        CFG_TELEPORT_LIFE = 3'd6,
        CFG_PRELOAD_LIFE  = 3'd7
    } t_cfg_index;

    typedef struct packed {
        t_action                    action;
        logic [REQ_W-1:0]           requester;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_z;
        logic signed [RIN_W-1:0]    radius_in;
    } t_in_item;

    typedef struct packed {
        logic                       slot_valid;
        logic signed [COORD_W-1:0]  slot_x;
        logic signed [COORD_W-1:0]  slot_z;
        logic [PRIO_W-1:0]          slot_priority;
        logic [RAD_W-1:0]           slot_radius;
        logic [EXP_W-1:0]           slot_expiry;
        logic [EPOCH_W-1:0]         epoch_now;
        logic [CNT32_W-1:0]         revision_now;
        logic [CNT32_W-1:0]         expired_total;
        logic [ACTIVE_W-1:0]        active_count;
    } t_out_item;

    typedef struct packed {
        logic                       en;
        t_action                    action;
        logic [COORD_W-1:0]         x;
        logic [COORD_W-1:0]         z;
        logic [PRIO_W-1:0]          priority_val;
        logic [RAD_W-1:0]           radius;
        logic [EXP_W-1:0]           expiry;
        logic [EPOCH_W-1:0]         epoch_next;
    } t_slot_cmd;

    typedef struct packed {
        logic                       valid;
        logic [COORD_W-1:0]         x;
        logic [COORD_W-1:0]         z;
        logic [PRIO_W-1:0]          priority_val;
        logic [RAD_W-1:0]           radius;
        logic [EXP_W-1:0]           expiry;
        logic                       bump;
        logic                       expire;
    } t_slot_stat;

    function automatic logic [RAD_W-1:0] clamp_radius(input logic signed [RIN_W-1:0] raw);
        logic [RAD_W-1:0] res;
        res = raw[RIN_W-1] ? '0 : raw[RAD_W-1:0];
        return res;
    endfunction

endpackage

@@ rtl/lte_if.sv @@
// Valid/ready channel interfaces of the lease table: input items, result items, config writes.
// Depends on lte_pkg for field widths.
interface lte_in_if
    import lte_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [REQ_W-1:0]           requester;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_z;
    logic signed [RIN_W-1:0]    radius_in;

    modport source (output valid, action, requester, coord_x, coord_z, radius_in,
                    input ready);
    modport sink   (input valid, action, requester, coord_x, coord_z, radius_in,
                    output ready);
endinterface

interface lte_out_if
    import lte_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       slot_valid;
    logic signed [COORD_W-1:0]  slot_x;
    logic signed [COORD_W-1:0]  slot_z;
    logic [PRIO_W-1:0]          slot_priority;
    logic [RAD_W-1:0]           slot_radius;
    logic [EXP_W-1:0]           slot_expiry;
    logic [EPOCH_W-1:0]         epoch_now;
    logic [CNT32_W-1:0]         revision_now;
    logic [CNT32_W-1:0]         expired_total;
    logic [ACTIVE_W-1:0]        active_count;

    modport source (output valid, slot_valid, slot_x, slot_z, slot_priority, slot_radius,
                    slot_expiry, epoch_now, revision_now, expired_total, active_count,
                    input ready);
    modport sink   (input valid, slot_valid, slot_x, slot_z, slot_priority, slot_radius,
                    slot_expiry, epoch_now, revision_now, expired_total, active_count,
                    output ready);
endinterface

interface lte_cfg_if
    import lte_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [CFG_IDX_W-1:0]       index;
    logic [CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/lte_slot.sv @@
// One lease slot: stored lease, its update for refresh, set radius and tick.
// Depends on lte_pkg; instantiated once per slot by the top level.
module lte_slot
    import lte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_slot_cmd  i_cmd,
    input  logic       i_hit,
    output t_slot_stat o_stat
);

    logic               r_valid;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_z;
    logic [PRIO_W-1:0]  r_prio;
    logic [RAD_W-1:0]   r_radius;
    logic [EXP_W-1:0]   r_expiry;

    logic               n_valid;
    logic [COORD_W-1:0] n_x;
    logic [COORD_W-1:0] n_z;
    logic [PRIO_W-1:0]  n_prio;
    logic [RAD_W-1:0]   n_radius;
    logic [EXP_W-1:0]   n_expiry;
    logic               w_bump;
    logic               w_expire;

    always_comb begin
        n_valid  = r_valid;
        n_x      = r_x;
        n_z      = r_z;
        n_prio   = r_prio;
        n_radius = r_radius;
        n_expiry = r_expiry;
        w_bump   = 1'b0;
        w_expire = 1'b0;
        case (i_cmd.action)
            ACT_REFRESH: begin
                if (i_hit) begin
                    w_bump   = !r_valid || (r_x != i_cmd.x) || (r_z != i_cmd.z)
                               || (r_prio != i_cmd.priority_val)
                               || (r_radius != i_cmd.radius);
                    n_valid  = 1'b1;
                    n_x      = i_cmd.x;
                    n_z      = i_cmd.z;
                    n_prio   = i_cmd.priority_val;
                    n_radius = i_cmd.radius;
                    n_expiry = i_cmd.expiry;
                end
            end
            ACT_SET_RADIUS: begin
                if (i_hit && r_valid && (r_radius != i_cmd.radius)) begin
                    n_radius = i_cmd.radius;
                    w_bump   = 1'b1;
                end
            end
            ACT_TICK: begin
                if (r_valid && ({1'b0, i_cmd.epoch_next} > r_expiry)) begin
                    n_valid  = 1'b0;
                    w_expire = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_x      <= n_x;
            r_z      <= n_z;
            r_prio   <= n_prio;
            r_radius <= n_radius;
            r_expiry <= n_expiry;
        end
    end

    assign o_stat.valid        = n_valid;
    assign o_stat.x            = n_x;
    assign o_stat.z            = n_z;
    assign o_stat.priority_val = n_prio;
    assign o_stat.radius       = n_radius;
    assign o_stat.expiry       = n_expiry;
    assign o_stat.bump         = w_bump;
    assign o_stat.expire       = w_expire;

endmodule

@@ rtl/lease_table_with_expiry_unit.sv @@
// Lease table with expiry: top level with config registers, input and result registers.
// Depends on lte_pkg, lte_if.sv, lte_slot and assert_macros.svh.
//
//   channel  dir  port   carries
//   -------  ---  -----  ------------------------------------------------
//   config   in   i_cfg  register index, write data; always ready
//   items    in   i_in   action, requester, coordinates, radius
//   results  out  o_out  addressed slot and global counters, one per item
//
// One item per cycle sustained while o_out is ready; an accepted item passes through the input
// register, then the result register. The slot update runs against all slots in parallel,
// combinationally between the two registers.
// Reset is synchronous on i_rst_n low: slots invalid, counters and config zero.
// A stalled result holds the input register, which holds one more item.
`include "assert_macros.svh"

module lease_table_with_expiry_unit
    import lte_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    lte_cfg_if.sink   i_cfg,
    lte_in_if.sink    i_in,
    lte_out_if.source o_out
);

    logic [PRIO_W-1:0]  r_prio [CLASS_COUNT];
    logic [LIFE_W-1:0]  r_life [CLASS_COUNT];

    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [EPOCH_W-1:0] r_epoch;
    logic [CNT32_W-1:0] r_revision;
    logic [CNT32_W-1:0] r_expired;

    logic [EPOCH_W-1:0] n_epoch;
    logic [CNT32_W-1:0] n_revision;
    logic [CNT32_W-1:0] n_expired;

    logic               w_advance;
    logic [EPOCH_W-1:0] w_epoch_next;
    t_slot_cmd          w_cmd;
    logic               w_hit  [SLOT_COUNT];
    t_slot_stat         w_stat [SLOT_COUNT];
    logic [CNT_W-1:0]   w_exp_n;
    logic [CNT_W-1:0]   w_active;
    logic               w_bump;
    t_out_item          w_res;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CLASS_COUNT; i++) begin
                r_prio[i] <= '0;
                r_life[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_PLAYER_PRIO:   r_prio[0] <= i_cfg.data[PRIO_W-1:0];
                CFG_CAMERA_PRIO:   r_prio[1] <= i_cfg.data[PRIO_W-1:0];
                CFG_TELEPORT_PRIO: r_prio[2] <= i_cfg.data[PRIO_W-1:0];
                CFG_PRELOAD_PRIO:  r_prio[3] <= i_cfg.data[PRIO_W-1:0];
                CFG_PLAYER_LIFE:   r_life[0] <= i_cfg.data[LIFE_W-1:0];
                CFG_CAMERA_LIFE:   r_life[1] <= i_cfg.data[LIFE_W-1:0];
                CFG_TELEPORT_LIFE: r_life[2] <= i_cfg.data[LIFE_W-1:0];
                CFG_PRELOAD_LIFE:  r_life[3] <= i_cfg.data[LIFE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.action    <= t_action'(i_in.action);
            r_in.requester <= i_in.requester;
            r_in.coord_x   <= i_in.coord_x;
            r_in.coord_z   <= i_in.coord_z;
            r_in.radius_in <= i_in.radius_in;
        end
    end

    // slot command
    assign w_epoch_next = (r_epoch == EPOCH_MAX) ? r_epoch : r_epoch + EPOCH_W'(1);

    always_comb begin
        w_cmd.en           = w_advance;
        w_cmd.action       = r_in.action;
        w_cmd.x            = r_in.coord_x;
        w_cmd.z            = r_in.coord_z;
        w_cmd.priority_val = r_prio[r_in.requester];
        w_cmd.radius       = clamp_radius(r_in.radius_in);
        w_cmd.expiry       = {1'b0, r_epoch} + EXP_W'(r_life[r_in.requester]);
        w_cmd.epoch_next   = w_epoch_next;
    end

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
        assign w_hit[g] = (32'(r_in.requester) == 32'(g));

        lte_slot u_slot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_hit   (w_hit[g]),
            .o_stat  (w_stat[g])
        );
    end

    // gather slot results
    always_comb begin
        w_exp_n  = '0;
        w_active = '0;
        w_bump   = 1'b0;
        w_res    = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_exp_n  = w_exp_n + CNT_W'(w_stat[i].expire);
            w_active = w_active + CNT_W'(w_stat[i].valid);
            w_bump   = w_bump | w_stat[i].bump;
            if (w_hit[i] && w_stat[i].valid) begin
                w_res.slot_valid    = 1'b1;
                w_res.slot_x        = w_stat[i].x;
                w_res.slot_z        = w_stat[i].z;
                w_res.slot_priority = w_stat[i].priority_val;
                w_res.slot_radius   = w_stat[i].radius;
                w_res.slot_expiry   = w_stat[i].expiry;
            end
        end
        n_epoch    = (r_in.action == ACT_TICK) ? w_epoch_next : r_epoch;
        n_revision = r_revision + CNT32_W'(w_exp_n) + CNT32_W'(w_bump);
        n_expired  = r_expired + CNT32_W'(w_exp_n);
        w_res.epoch_now     = n_epoch;
        w_res.revision_now  = n_revision;
        w_res.expired_total = n_expired;
        w_res.active_count  = (32'(w_active) > ACTIVE_MAX) ? ACTIVE_W'(ACTIVE_MAX)
                                                           : ACTIVE_W'(w_active);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch    <= '0;
            r_revision <= '0;
            r_expired  <= '0;
        end else if (w_advance) begin
            r_epoch    <= n_epoch;
            r_revision <= n_revision;
            r_expired  <= n_expired;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.slot_valid    = r_out.slot_valid;
    assign o_out.slot_x        = r_out.slot_x;
    assign o_out.slot_z        = r_out.slot_z;
    assign o_out.slot_priority = r_out.slot_priority;
    assign o_out.slot_radius   = r_out.slot_radius;
    assign o_out.slot_expiry   = r_out.slot_expiry;
    assign o_out.epoch_now     = r_out.epoch_now;
    assign o_out.revision_now  = r_out.revision_now;
    assign o_out.expired_total = r_out.expired_total;
    assign o_out.active_count  = r_out.active_count;

    `LTE_ASSERT_NEXT(a_stall_holds_revision, i_clk, i_rst_n,
        r_out_valid && !o_out.ready, $stable(r_revision))
    `LTE_ASSERT_NEXT(a_expired_only_on_tick, i_clk, i_rst_n,
        !(w_advance && (r_in.action == ACT_TICK)), $stable(r_expired))
    `LTE_ASSERT_NEXT(a_held_item_kept, i_clk, i_rst_n,
        r_in_valid && !w_advance, r_in_valid && $stable(r_in))

endmodule
